// ===== rtl/two_line_closest_approach_core_macros.svh =====
// assertion helpers used by the checker file
`ifndef TWO_LINE_CLOSEST_APPROACH_CORE_MACROS_SVH
`define TWO_LINE_CLOSEST_APPROACH_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define CLAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clap check failed");

// next-cycle implication, quiet while in reset
`define CLAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clap check failed");

`endif

// ===== rtl/clap_pkg.sv =====
package clap_pkg;

    localparam int AXES = 3;
    localparam int PW   = 32;              // position width
    localparam int DW   = 18;              // direction width
    localparam int CHW  = 32;              // multiplier chunk width
    localparam int D0W  = PW + 1;          // point difference and sum
    localparam int ABW  = 2 * DW + 2;      // a, b, c
    localparam int DEW  = DW + D0W + 2;    // d, e
    localparam int DENW = 2 * ABW + 1;     // denominator
    localparam int PNW  = ABW + DEW;       // b*e and friends
    localparam int NSW  = PNW + 1;         // num_s, num_t
    localparam int PRW  = NSW + DW;        // per-term products of the numerator
    localparam int NUMW = PRW + 2;         // full numerator
    localparam int D2W  = DENW + 1;        // twice the denominator

    localparam int FRONT = 11;
    localparam int LAT   = FRONT + PW + 1;

    localparam int IN_FW  = 6 * PW + 6 * DW;
    localparam int IN_W   = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW = AXES * PW;
    localparam int OUT_W  = ((OUT_FW + 7) / 8) * 8;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_PARALLEL = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT      = 2'd2;

    typedef struct packed {
        logic [NUMW-1:0] mag;
        logic [D2W-1:0]  dv;
        logic            neg;
        logic            ovf;
    } div_in_t;

    typedef struct packed {
        logic [PW-1:0] q;
        logic          neg;
        logic          ovf;
    } div_out_t;

endpackage

// ===== rtl/two_line_closest_approach_core.sv =====
// pipeline from input transfer to result: 11 arithmetic stages, 32 divider stages,
// one output register
// throughput: one item per cycle while the output is not stalled; the quotient comes
// from a 32-stage restoring divider per axis, one bit per stage
// a stalled output freezes the whole pipeline, nothing is dropped
// reset (rst_n low, asynchronous) clears all valid bits; payload is not reset
module two_line_closest_approach_core
    import clap_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // line1_px, line1_py, line1_pz, line1_dx, line1_dy, line1_dz,
    // line2_px, line2_py, line2_pz, line2_dx, line2_dy, line2_dz, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // vertex_x, vertex_y, vertex_z
    output logic [OUT_W-1:0] m_tdata,
    // status
    output logic [ST_W-1:0]  m_tuser
);

    logic en;
    logic v_reg [LAT];

    logic signed [PW-1:0] p1 [AXES];
    logic signed [PW-1:0] p2 [AXES];
    logic signed [DW-1:0] d1 [AXES];
    logic signed [DW-1:0] d2 [AXES];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            p1[i] = $signed(s_tdata[i*PW +: PW]);
            d1[i] = $signed(s_tdata[3*PW + i*DW +: DW]);
            p2[i] = $signed(s_tdata[3*PW + 3*DW + i*PW +: PW]);
            d2[i] = $signed(s_tdata[6*PW + 3*DW + i*DW +: DW]);
        end
    end

    assign en       = !v_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k < LAT; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // carried along the front stages
    logic signed [D0W-1:0] sp_1_reg [AXES], sp_2_reg [AXES], sp_3_reg [AXES];
    logic signed [D0W-1:0] sp_4_reg [AXES], sp_5_reg [AXES], sp_6_reg [AXES];
    logic signed [DW-1:0]  d1_1_reg [AXES], d1_2_reg [AXES], d1_3_reg [AXES];
    logic signed [DW-1:0]  d1_4_reg [AXES], d1_5_reg [AXES], d1_6_reg [AXES];
    logic signed [DW-1:0]  d2_1_reg [AXES], d2_2_reg [AXES], d2_3_reg [AXES];
    logic signed [DW-1:0]  d2_4_reg [AXES], d2_5_reg [AXES], d2_6_reg [AXES];

    // stage 1
    logic signed [D0W-1:0]  d0_1_reg  [AXES];
    logic signed [2*DW-1:0] m11_1_reg [AXES];
    logic signed [2*DW-1:0] m12_1_reg [AXES];
    logic signed [2*DW-1:0] m22_1_reg [AXES];
    // stage 2
    logic signed [ABW-1:0]    a_2_reg, b_2_reg, c_2_reg;
    logic signed [DW+D0W-1:0] md1_2_reg [AXES];
    logic signed [DW+D0W-1:0] md2_2_reg [AXES];
    // stage 3
    logic signed [ABW-1:0]       a_3_reg, b_3_reg, c_3_reg;
    logic signed [DEW-1:0]       d_3_reg, e_3_reg;
    logic signed [ABW+CHW:0]     ac_l_3_reg, bb_l_3_reg;
    logic signed [2*ABW-CHW-1:0] ac_h_3_reg, bb_h_3_reg;
    // stage 4
    logic signed [2*ABW-1:0]     ac_4_reg, bb_4_reg;
    logic signed [ABW+CHW:0]     be_l_4_reg, cd_l_4_reg, ae_l_4_reg, bd_l_4_reg;
    logic signed [PNW-CHW-1:0]   be_h_4_reg, cd_h_4_reg, ae_h_4_reg, bd_h_4_reg;
    // stage 5
    logic signed [DENW-1:0] den_5_reg;
    logic signed [PNW-1:0]  be_5_reg, cd_5_reg, ae_5_reg, bd_5_reg;
    // stage 6
    logic signed [DENW-1:0] den_6_reg;
    logic signed [NSW-1:0]  ns_6_reg, nt_6_reg;
    // stage 7
    logic signed [D0W+CHW:0]        sd0_7_reg [AXES], sd1_7_reg [AXES];
    logic signed [D0W+DENW-2*CHW-1:0] sd2_7_reg [AXES];
    logic signed [DW+CHW:0]         ns0_7_reg [AXES], ns1_7_reg [AXES];
    logic signed [DW+NSW-2*CHW-1:0] ns2_7_reg [AXES];
    logic signed [DW+CHW:0]         nt0_7_reg [AXES], nt1_7_reg [AXES];
    logic signed [DW+NSW-2*CHW-1:0] nt2_7_reg [AXES];
    logic signed [DENW-1:0]         den_7_reg;
    logic                           dz_7_reg;
    // stage 8
    logic signed [PRW-1:0] sden_8_reg [AXES], nsd_8_reg [AXES], ntd_8_reg [AXES];
    logic [D2W-1:0]        d2x_8_reg;
    logic                  dz_8_reg;
    // stage 9
    logic signed [NUMW-1:0] num_9_reg [AXES];
    logic [NUMW-1:0]        thrp_9_reg, thrn_9_reg;
    logic [D2W-1:0]         d2x_9_reg;
    logic                   dz_9_reg;
    // stage 10
    logic [NUMW-1:0] mag_10_reg [AXES];
    logic            neg_10_reg [AXES];
    logic [NUMW-1:0] thrp_10_reg, thrn_10_reg;
    logic [D2W-1:0]  d2x_10_reg;
    logic            dz_10_reg;
    // stage 11
    logic [NUMW-1:0] mag_11_reg [AXES];
    logic            neg_11_reg [AXES];
    logic            ovf_11_reg [AXES];
    logic [D2W-1:0]  d2x_11_reg;
    logic            dz_11_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: differences, sums, direction products
            for (int i = 0; i < AXES; i++)
            begin
                d0_1_reg[i]  <= p1[i] - p2[i];
                sp_1_reg[i]  <= p1[i] + p2[i];
                d1_1_reg[i]  <= d1[i];
                d2_1_reg[i]  <= d2[i];
                m11_1_reg[i] <= d1[i] * d1[i];
                m12_1_reg[i] <= d1[i] * d2[i];
                m22_1_reg[i] <= d2[i] * d2[i];
            end

            // stage 2: a, b, c and the products for d, e
            a_2_reg <= m11_1_reg[0] + m11_1_reg[1] + m11_1_reg[2];
            b_2_reg <= m12_1_reg[0] + m12_1_reg[1] + m12_1_reg[2];
            c_2_reg <= m22_1_reg[0] + m22_1_reg[1] + m22_1_reg[2];
            for (int i = 0; i < AXES; i++)
            begin
                md1_2_reg[i] <= d1_1_reg[i] * d0_1_reg[i];
                md2_2_reg[i] <= d2_1_reg[i] * d0_1_reg[i];
                sp_2_reg[i]  <= sp_1_reg[i];
                d1_2_reg[i]  <= d1_1_reg[i];
                d2_2_reg[i]  <= d2_1_reg[i];
            end

            // stage 3: d, e and split products a*c, b*b
            d_3_reg    <= md1_2_reg[0] + md1_2_reg[1] + md1_2_reg[2];
            e_3_reg    <= md2_2_reg[0] + md2_2_reg[1] + md2_2_reg[2];
            ac_l_3_reg <= a_2_reg * $signed({1'b0, c_2_reg[CHW-1:0]});
            ac_h_3_reg <= a_2_reg * $signed(c_2_reg[ABW-1:CHW]);
            bb_l_3_reg <= b_2_reg * $signed({1'b0, b_2_reg[CHW-1:0]});
            bb_h_3_reg <= b_2_reg * $signed(b_2_reg[ABW-1:CHW]);
            a_3_reg    <= a_2_reg;
            b_3_reg    <= b_2_reg;
            c_3_reg    <= c_2_reg;
            for (int i = 0; i < AXES; i++)
            begin
                sp_3_reg[i] <= sp_2_reg[i];
                d1_3_reg[i] <= d1_2_reg[i];
                d2_3_reg[i] <= d2_2_reg[i];
            end

            // stage 4
            ac_4_reg   <= (ac_h_3_reg <<< CHW) + ac_l_3_reg;
            bb_4_reg   <= (bb_h_3_reg <<< CHW) + bb_l_3_reg;
            be_l_4_reg <= b_3_reg * $signed({1'b0, e_3_reg[CHW-1:0]});
            be_h_4_reg <= b_3_reg * $signed(e_3_reg[DEW-1:CHW]);
            cd_l_4_reg <= c_3_reg * $signed({1'b0, d_3_reg[CHW-1:0]});
            cd_h_4_reg <= c_3_reg * $signed(d_3_reg[DEW-1:CHW]);
            ae_l_4_reg <= a_3_reg * $signed({1'b0, e_3_reg[CHW-1:0]});
            ae_h_4_reg <= a_3_reg * $signed(e_3_reg[DEW-1:CHW]);
            bd_l_4_reg <= b_3_reg * $signed({1'b0, d_3_reg[CHW-1:0]});
            bd_h_4_reg <= b_3_reg * $signed(d_3_reg[DEW-1:CHW]);
            for (int i = 0; i < AXES; i++)
            begin
                sp_4_reg[i] <= sp_3_reg[i];
                d1_4_reg[i] <= d1_3_reg[i];
                d2_4_reg[i] <= d2_3_reg[i];
            end

            // stage 5
            den_5_reg <= ac_4_reg - bb_4_reg;
            be_5_reg  <= (be_h_4_reg <<< CHW) + be_l_4_reg;
            cd_5_reg  <= (cd_h_4_reg <<< CHW) + cd_l_4_reg;
            ae_5_reg  <= (ae_h_4_reg <<< CHW) + ae_l_4_reg;
            bd_5_reg  <= (bd_h_4_reg <<< CHW) + bd_l_4_reg;
            for (int i = 0; i < AXES; i++)
            begin
                sp_5_reg[i] <= sp_4_reg[i];
                d1_5_reg[i] <= d1_4_reg[i];
                d2_5_reg[i] <= d2_4_reg[i];
            end

            // stage 6
            ns_6_reg  <= be_5_reg - cd_5_reg;
            nt_6_reg  <= ae_5_reg - bd_5_reg;
            den_6_reg <= den_5_reg;
            for (int i = 0; i < AXES; i++)
            begin
                sp_6_reg[i] <= sp_5_reg[i];
                d1_6_reg[i] <= d1_5_reg[i];
                d2_6_reg[i] <= d2_5_reg[i];
            end

            // stage 7: chunked products of the numerator terms
            for (int i = 0; i < AXES; i++)
            begin
                sd0_7_reg[i] <= sp_6_reg[i] * $signed({1'b0, den_6_reg[CHW-1:0]});
                sd1_7_reg[i] <= sp_6_reg[i] * $signed({1'b0, den_6_reg[2*CHW-1:CHW]});
                sd2_7_reg[i] <= sp_6_reg[i] * $signed(den_6_reg[DENW-1:2*CHW]);
                ns0_7_reg[i] <= d1_6_reg[i] * $signed({1'b0, ns_6_reg[CHW-1:0]});
                ns1_7_reg[i] <= d1_6_reg[i] * $signed({1'b0, ns_6_reg[2*CHW-1:CHW]});
                ns2_7_reg[i] <= d1_6_reg[i] * $signed(ns_6_reg[NSW-1:2*CHW]);
                nt0_7_reg[i] <= d2_6_reg[i] * $signed({1'b0, nt_6_reg[CHW-1:0]});
                nt1_7_reg[i] <= d2_6_reg[i] * $signed({1'b0, nt_6_reg[2*CHW-1:CHW]});
                nt2_7_reg[i] <= d2_6_reg[i] * $signed(nt_6_reg[NSW-1:2*CHW]);
            end
            den_7_reg <= den_6_reg;
            dz_7_reg  <= (den_6_reg == '0);

            // stage 8
            for (int i = 0; i < AXES; i++)
            begin
                sden_8_reg[i] <= (sd2_7_reg[i] <<< (2*CHW)) + (sd1_7_reg[i] <<< CHW)
                                 + sd0_7_reg[i];
                nsd_8_reg[i]  <= (ns2_7_reg[i] <<< (2*CHW)) + (ns1_7_reg[i] <<< CHW)
                                 + ns0_7_reg[i];
                ntd_8_reg[i]  <= (nt2_7_reg[i] <<< (2*CHW)) + (nt1_7_reg[i] <<< CHW)
                                 + nt0_7_reg[i];
            end
            d2x_8_reg <= {den_7_reg, 1'b0};
            dz_8_reg  <= dz_7_reg;

            // stage 9: numerator and the saturation thresholds
            for (int i = 0; i < AXES; i++)
                num_9_reg[i] <= sden_8_reg[i] + nsd_8_reg[i] + ntd_8_reg[i];
            thrp_9_reg <= NUMW'(d2x_8_reg) << (PW - 1);
            thrn_9_reg <= (NUMW'(d2x_8_reg) << (PW - 1)) + NUMW'(d2x_8_reg);
            d2x_9_reg  <= d2x_8_reg;
            dz_9_reg   <= dz_8_reg;

            // stage 10: magnitude
            for (int i = 0; i < AXES; i++)
            begin
                neg_10_reg[i] <= num_9_reg[i][NUMW-1];
                mag_10_reg[i] <= num_9_reg[i][NUMW-1] ? NUMW'(-num_9_reg[i])
                                                      : NUMW'(num_9_reg[i]);
            end
            thrp_10_reg <= thrp_9_reg;
            thrn_10_reg <= thrn_9_reg;
            d2x_10_reg  <= d2x_9_reg;
            dz_10_reg   <= dz_9_reg;

            // stage 11: out-of-range check, a negative quotient may reach the minimum
            for (int i = 0; i < AXES; i++)
            begin
                ovf_11_reg[i] <= neg_10_reg[i] ? (mag_10_reg[i] >= thrn_10_reg)
                                               : (mag_10_reg[i] >= thrp_10_reg);
                mag_11_reg[i] <= mag_10_reg[i];
                neg_11_reg[i] <= neg_10_reg[i];
            end
            d2x_11_reg <= d2x_10_reg;
            dz_11_reg  <= dz_10_reg;
        end
    end

    div_in_t  div_in  [AXES];
    div_out_t div_out [AXES];

    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        assign div_in[g].mag = mag_11_reg[g];
        assign div_in[g].dv  = d2x_11_reg;
        assign div_in[g].neg = neg_11_reg[g];
        assign div_in[g].ovf = ovf_11_reg[g];

        clap_div u_div
        (
            .clk  (clk),
            .en   (en),
            .din  (div_in[g]),
            .dout (div_out[g])
        );
    end

    // parallel flag rides beside the dividers
    logic dz_pipe_reg [PW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_pipe_reg[0] <= dz_11_reg;
            for (int k = 1; k < PW; k++)
                dz_pipe_reg[k] <= dz_pipe_reg[k-1];
        end
    end

    logic [PW-1:0]   vtx_next [AXES];
    logic [ST_W-1:0] status_next;
    logic [PW-1:0]   vtx_reg  [AXES];
    logic [ST_W-1:0] status_reg;

    always_comb
    begin
        status_next = ST_OK;
        for (int i = 0; i < AXES; i++)
        begin
            if (dz_pipe_reg[PW-1])
                vtx_next[i] = '0;
            else if (div_out[i].ovf)
                vtx_next[i] = div_out[i].neg ? {1'b1, {(PW-1){1'b0}}}
                                             : {1'b0, {(PW-1){1'b1}}};
            else
                vtx_next[i] = div_out[i].neg ? PW'(-div_out[i].q) : div_out[i].q;
            if (div_out[i].ovf)
                status_next = ST_SAT;
        end
        if (dz_pipe_reg[PW-1])
            status_next = ST_PARALLEL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < AXES; i++)
                vtx_reg[i] <= vtx_next[i];
            status_reg <= status_next;
        end
    end

    assign m_tvalid = v_reg[LAT-1];
    assign m_tdata  = OUT_W'({vtx_reg[2], vtx_reg[1], vtx_reg[0]});
    assign m_tuser  = status_reg;

endmodule

// ===== rtl/clap_div.sv =====
module clap_div
    import clap_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  div_in_t  din,
    output div_out_t dout
);

    logic [NUMW-1:0] rem_reg [PW];
    logic [PW-1:0]   q_reg   [PW];
    logic [D2W-1:0]  dv_reg  [PW];
    logic            neg_reg [PW];
    logic            ovf_reg [PW];

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < PW; i++)
    begin : g_stage
        localparam int K = PW - 1 - i;
        logic [NUMW-1:0] rem_in;
        logic [NUMW-1:0] shifted;
        logic [PW-1:0]   q_in;
        logic [D2W-1:0]  dv_in;
        logic            neg_in;
        logic            ovf_in;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                rem_in = din.mag;
                q_in   = '0;
                dv_in  = din.dv;
                neg_in = din.neg;
                ovf_in = din.ovf;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                rem_in = rem_reg[i-1];
                q_in   = q_reg[i-1];
                dv_in  = dv_reg[i-1];
                neg_in = neg_reg[i-1];
                ovf_in = ovf_reg[i-1];
            end
        end

        assign shifted = NUMW'(dv_in) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= shifted)
                begin
                    rem_reg[i] <= rem_in - shifted;
                    q_reg[i]   <= q_in | (PW'(1) << K);
                end
                else
                begin
                    rem_reg[i] <= rem_in;
                    q_reg[i]   <= q_in;
                end
                dv_reg[i]  <= dv_in;
                neg_reg[i] <= neg_in;
                ovf_reg[i] <= ovf_in;
            end
        end
    end

    assign dout.q   = q_reg[PW-1];
    assign dout.neg = neg_reg[PW-1];
    assign dout.ovf = ovf_reg[PW-1];

endmodule

// ===== rtl/clap_checker.sv =====
`include "two_line_closest_approach_core_macros.svh"

module clap_checker
    import clap_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [ST_W-1:0]  m_tuser
);

    `CLAP_ASSERT_NOW(a_parallel_zero, clk, rst_n, m_tvalid && m_tuser == ST_PARALLEL,
                     m_tdata == '0)
    `CLAP_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid,
                     m_tuser == ST_OK || m_tuser == ST_PARALLEL || m_tuser == ST_SAT)
    `CLAP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)
    `CLAP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind two_line_closest_approach_core clap_checker u_clap_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
